>>> rtl/core/toeq_pkg.sv
// Package for the time-ordered event queue: sizes, field widths, status codes
// and the entry and cell-control types. No dependencies.
package toeq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] ev_time;
    logic [KIND_BITS-1:0] kind;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  // per-cell control from the queue front end
  typedef struct packed {
    logic ins;        // insert taking effect this cycle
    logic pop;        // pop taking effect this cycle
    logic occ;        // this cell holds a live entry
    logic prev_keep;  // left neighbor keeps its entry (tied high at the head)
  } cell_ctrl_t;

endpackage

>>> rtl/core/toeq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the entry
// being inserted and shifts toward either neighbor. Depends on toeq_pkg.
module toeq_cell (
  input  logic                clk_i,
  input  toeq_pkg::cell_ctrl_t ctrl_i,
  input  toeq_pkg::entry_t    new_i,
  input  toeq_pkg::entry_t    prev_i,
  input  toeq_pkg::entry_t    next_i,
  output toeq_pkg::entry_t    entry_o,
  output logic                keep_o
);

  toeq_pkg::entry_t entry_q, entry_d;

  // equal or earlier entries stay in front of the new one
  assign keep_o = ctrl_i.occ && (entry_q.ev_time <= new_i.ev_time);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (ctrl_i.prev_keep) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/core/time_ordered_event_queue.sv
// Top level of the time-ordered event queue: request decode, fill count,
// result register and the chain of toeq_cell slots. Depends on toeq_pkg.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | event_time, event_kind, event_tag       | req_type
//  m_axis   | out | popped_time, popped_kind, popped_tag,   | popped_valid, status
//           |     | occupancy                               |
//
// One request per cycle while the output is not stalled: every cell compares its
// time with the new entry in parallel and shifts one place in the same cycle; the
// result is registered on the transfer, valid in the next cycle. The result register
// frees up in the cycle it is taken, so a stalled output holds back only the next
// request. Reset clears the fill count and output valid; the cells need no reset.
module time_ordered_event_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] event_time, [33:32] event_kind, [49:34] event_tag, [55:50] zero
  input  logic [55:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] popped_time, [33:32] popped_kind, [49:34] popped_tag,
  // [54:50] occupancy, [55] zero
  output logic [55:0] m_axis_tdata_o,
  // [0] popped_valid, [2:1] status
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned DEPTH = toeq_pkg::QUEUE_DEPTH;

  toeq_pkg::entry_t     new_entry;
  toeq_pkg::entry_t     cell_q    [DEPTH];
  toeq_pkg::entry_t     cell_prev [DEPTH];
  toeq_pkg::entry_t     cell_next [DEPTH];
  toeq_pkg::cell_ctrl_t cell_ctrl [DEPTH];
  logic [DEPTH-1:0]     keep;

  logic [toeq_pkg::CNT_W-1:0] count_q, count_d;
  logic in_fire, req_pop, is_full, is_empty, do_ins, do_pop;

  logic                             out_valid_q;
  logic                             res_valid_q, res_valid_d;
  toeq_pkg::entry_t                 res_entry_q, res_entry_d;
  logic [toeq_pkg::STATUS_W-1:0]    res_status_q, res_status_d;
  logic [toeq_pkg::OCC_W-1:0]       res_occ_q, res_occ_d;

  assign new_entry.ev_time = s_axis_tdata_i[31:0];
  assign new_entry.kind    = s_axis_tdata_i[33:32];
  assign new_entry.tag     = s_axis_tdata_i[49:34];
  assign req_pop           = (s_axis_tuser_i == toeq_pkg::REQ_POP);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full         = (count_q == toeq_pkg::CNT_W'(DEPTH));
  assign is_empty        = (count_q == '0);
  assign do_ins          = in_fire && !req_pop && !is_full;
  assign do_pop          = in_fire && req_pop && !is_empty;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      assign cell_prev[gi]           = new_entry;
      assign cell_ctrl[gi].prev_keep = 1'b1;
    end else begin : g_body
      assign cell_prev[gi]           = cell_q[gi-1];
      assign cell_ctrl[gi].prev_keep = keep[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_tail
      assign cell_next[gi] = '0;
    end else begin : g_inner
      assign cell_next[gi] = cell_q[gi+1];
    end
    assign cell_ctrl[gi].ins = do_ins;
    assign cell_ctrl[gi].pop = do_pop;
    assign cell_ctrl[gi].occ = (toeq_pkg::CNT_W'(gi) < count_q);

    toeq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[gi]),
      .new_i   (new_entry),
      .prev_i  (cell_prev[gi]),
      .next_i  (cell_next[gi]),
      .entry_o (cell_q[gi]),
      .keep_o  (keep[gi])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + toeq_pkg::CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - toeq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    res_valid_d  = 1'b0;
    res_entry_d  = '0;
    res_status_d = toeq_pkg::ST_OK;
    if (req_pop) begin
      if (is_empty) begin
        res_status_d = toeq_pkg::ST_EMPTY;
      end else begin
        res_valid_d = 1'b1;
        res_entry_d = cell_q[0];
      end
    end else if (is_full) begin
      res_status_d = toeq_pkg::ST_FULL;
    end
    res_occ_d = toeq_pkg::OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_valid_q  <= res_valid_d;
      res_entry_q  <= res_entry_d;
      res_status_q <= res_status_d;
      res_occ_q    <= res_occ_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_occ_q, res_entry_q.tag, res_entry_q.kind,
                            res_entry_q.ev_time};
  assign m_axis_tuser_o  = {res_status_q, res_valid_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= toeq_pkg::CNT_W'(DEPTH))
    else $error("fill count above queue depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + toeq_pkg::CNT_W'(1))
    else $error("insert did not grow the queue");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_pop && is_empty) |=>
      (m_axis_tvalid_o && m_axis_tuser_o[2:1] == toeq_pkg::ST_EMPTY && count_q == '0))
    else $error("pop on empty not flagged or queue changed");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tuser_o[2:1] == toeq_pkg::ST_OK)
    else $error("popped entry with error status");

endmodule

>>> verif/tb_time_ordered_event_queue.sv
// Self-checking testbench for time_ordered_event_queue: directed table, then random
// insert/pop phases, checked against a sorted-queue model kept here.
// Depends on toeq_pkg and the time_ordered_event_queue RTL.
module tb_time_ordered_event_queue;

  localparam int unsigned N_ITEMS   = 1050;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned LONG_HOLD = 120;

  typedef struct packed {
    logic             req;
    toeq_pkg::entry_t ev;
  } sched_req_t;

  typedef struct packed {
    logic                           vld;
    logic [toeq_pkg::TIME_BITS-1:0] ev_time;
    logic [toeq_pkg::KIND_BITS-1:0] kind;
    logic [toeq_pkg::TAG_BITS-1:0]  tag;
    logic [toeq_pkg::STATUS_W-1:0]  status;
    logic [toeq_pkg::OCC_W-1:0]     occ;
  } sched_res_t;

  typedef struct {
    sched_req_t rq;
    bit         typed;
    sched_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  toeq_pkg::entry_t sched_q[$];   // model of the stored events, earliest first
  sched_res_t  pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned fail_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_stall = 0;
  bit          held_once = 1'b0;
  bit          calm = 1'b0;

  time_ordered_event_queue i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones; none at all during calm stretches
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // stable sorted insert / pop of the earliest event
  function automatic sched_res_t apply_to_schedule(input sched_req_t rq);
    sched_res_t       res;
    toeq_pkg::entry_t head;
    int unsigned      pos;
    res = '0;
    res.status = toeq_pkg::ST_OK;
    if (rq.req == toeq_pkg::REQ_INSERT) begin
      if (sched_q.size() >= toeq_pkg::QUEUE_DEPTH) begin
        res.status = toeq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sched_q.size() && sched_q[pos].ev_time <= rq.ev.ev_time) pos++;
        sched_q.insert(pos, rq.ev);
      end
    end else begin
      if (sched_q.size() == 0) begin
        res.status = toeq_pkg::ST_EMPTY;
      end else begin
        head        = sched_q.pop_front();
        res.vld     = 1'b1;
        res.ev_time = head.ev_time;
        res.kind    = head.kind;
        res.tag     = head.tag;
      end
    end
    res.occ = toeq_pkg::OCC_W'(sched_q.size());
    return res;
  endfunction

  function automatic void add_row(input logic req, input logic [31:0] t, input logic [1:0] k,
                                  input logic [15:0] g, input bit typed, input sched_res_t res);
    dir_row_t row;
    row.rq.req        = req;
    row.rq.ev.ev_time = t;
    row.rq.ev.kind    = k;
    row.rq.ev.tag     = g;
    row.typed         = typed;
    row.res           = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // valid is only lowered when a gap follows, so it never toggles within one step
  task automatic send_item(input sched_req_t rq, input bit typed, input sched_res_t typed_res);
    int unsigned gap;
    sched_res_t  res;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rq.req;
    s_axis_tdata_i  <= {6'b0, rq.ev.tag, rq.ev.kind, rq.ev.ev_time};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    res = apply_to_schedule(rq);
    pending_results.push_back(typed ? typed_res : res);
    sent++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the queue up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!held_once && results_seen >= 200) begin
      held_once       <= 1'b1;
      rx_stall        <= LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall        <= rx_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_stall        <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("popped_valid", want.vld, m_axis_tuser_o[0]);
        check_field("status", want.status, m_axis_tuser_o[2:1]);
        check_field("popped_time", want.ev_time, m_axis_tdata_o[31:0]);
        check_field("popped_kind", want.kind, m_axis_tdata_o[33:32]);
        check_field("popped_tag", want.tag, m_axis_tdata_o[49:34]);
        check_field("occupancy", want.occ, m_axis_tdata_o[54:50]);
      end
    end
  end

  initial begin
    sched_res_t  r0;
    sched_req_t  rq;
    int unsigned phase_len;
    int unsigned pop_pct;
    int unsigned sel;

    // directed table: typed results only where obvious
    r0 = '0;
    r0.status = toeq_pkg::ST_EMPTY;
    add_row(toeq_pkg::REQ_POP, 32'd0, 2'd0, 16'h0000, 1'b1, r0);   // pop on empty after reset
    r0 = '0;
    r0.occ = 5'd1;
    add_row(toeq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 2'd2, 16'hFFFF, 1'b1, r0);  // max time, tag
    r0.occ = 5'd2;
    add_row(toeq_pkg::REQ_INSERT, 32'd0, 2'd0, 16'h0000, 1'b1, r0); // min time goes first
    add_row(toeq_pkg::REQ_INSERT, 32'd100, 2'd1, 16'h0001, 1'b0, '0);
    add_row(toeq_pkg::REQ_INSERT, 32'd100, 2'd3, 16'h0002, 1'b0, '0);  // tie, kind code three
    add_row(toeq_pkg::REQ_INSERT, 32'd100, 2'd2, 16'h0003, 1'b0, '0);
    repeat (3) add_row(toeq_pkg::REQ_POP, 32'h5555_5555, 2'd3, 16'hA5A5, 1'b0, '0);
    // descending times with ties: each new time lands at the head, a tie just behind its equal
    for (int i = 0; i < 14; i++)
      add_row(toeq_pkg::REQ_INSERT, 32'd90 - 32'(i / 2) * 7, 2'(i % 4), 16'h0100 + 16'(i),
              1'b0, '0);
    r0 = '0;
    r0.status = toeq_pkg::ST_FULL;
    r0.occ    = 5'd16;
    add_row(toeq_pkg::REQ_INSERT, 32'd5, 2'd1, 16'hAAAA, 1'b1, r0);  // insert when full
    add_row(toeq_pkg::REQ_POP, 32'd0, 2'd0, 16'h0000, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);

    // random phases: fill-heavy, balanced, drain-heavy
    while (sent < N_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       pop_pct = 15;
        1:       pop_pct = 50;
        default: pop_pct = 85;
      endcase
      for (int i = 0; i < phase_len && sent < N_ITEMS; i++) begin
        rq.req = ($urandom_range(0, 99) < pop_pct) ? toeq_pkg::REQ_POP : toeq_pkg::REQ_INSERT;
        sel    = $urandom_range(0, 9);
        if (sel < 4)      rq.ev.ev_time = $urandom_range(0, 15);   // dense ties
        else if (sel < 6) rq.ev.ev_time = ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0)
                                          ^ 32'($urandom_range(0, 1));
        else              rq.ev.ev_time = $urandom;
        rq.ev.kind = 2'($urandom_range(0, 3));
        rq.ev.tag  = 16'($urandom_range(0, 65535));
        send_item(rq, 1'b0, '0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
